>>> rtl/aesp_pkg.sv
`default_nettype none

package aesp_pkg;

    // Screen limits and field widths
    localparam logic [7:0] MAX_COLUMNS = 8'd128;
    localparam logic [6:0] MAX_ROWS    = 7'd64;
    localparam int unsigned PARAM_CHARS = 16;

    localparam int unsigned COL_W   = 7;
    localparam int unsigned ROW_W   = 6;
    localparam int unsigned NUM_W   = 16;
    localparam int unsigned CELL_W  = 14;
    localparam int unsigned CHARS_W = 5;

    localparam logic [NUM_W-1:0]   NUM_MAX     = 16'hFFFF;
    localparam logic [CHARS_W-1:0] CHARS_LIMIT = 5'(PARAM_CHARS);

    // Command queue between the parser and the executer
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

    // Configuration register indexes
    localparam logic [1:0] REG_SCREEN_COLUMNS    = 2'd0;
    localparam logic [1:0] REG_SCREEN_ROWS       = 2'd1;
    localparam logic [1:0] REG_DEFAULT_ATTRIBUTE = 2'd2;

    // Configuration reset values
    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET    = 7'd25;
    localparam logic [7:0] ATTR_RESET    = 8'd7;

    // Sequence characters
    localparam logic [7:0] CHAR_BRACKET = 8'h5B;
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UP      = 8'h41;
    localparam logic [7:0] CHAR_DOWN    = 8'h42;
    localparam logic [7:0] CHAR_RIGHT   = 8'h43;
    localparam logic [7:0] CHAR_LEFT    = 8'h44;
    localparam logic [7:0] CHAR_PLACE   = 8'h48;
    localparam logic [7:0] CHAR_ERASE   = 8'h4A;
    localparam logic [7:0] CHAR_SGR     = 8'h6D;

    // Erase codes
    localparam logic [NUM_W-1:0] ERASE_TO_END     = 16'd0;
    localparam logic [NUM_W-1:0] ERASE_TO_CURSOR  = 16'd1;
    localparam logic [NUM_W-1:0] ERASE_ALL        = 16'd2;
    localparam logic [NUM_W-1:0] ERASE_ALL_SCROLL = 16'd3;

    // Select graphic rendition codes
    localparam logic [NUM_W-1:0] SGR_RESET      = 16'd0;
    localparam logic [NUM_W-1:0] SGR_BRIGHT     = 16'd1;
    localparam logic [NUM_W-1:0] SGR_FLASH_SLOW = 16'd5;
    localparam logic [NUM_W-1:0] SGR_FLASH_FAST = 16'd6;
    localparam logic [NUM_W-1:0] SGR_NORMAL     = 16'd22;
    localparam logic [NUM_W-1:0] SGR_STEADY     = 16'd25;
    localparam logic [NUM_W-1:0] SGR_PEN_FIRST  = 16'd30;
    localparam logic [NUM_W-1:0] SGR_PEN_LAST   = 16'd37;
    localparam logic [NUM_W-1:0] SGR_BACK_FIRST = 16'd40;
    localparam logic [NUM_W-1:0] SGR_BACK_LAST  = 16'd47;

    // Attribute bit positions
    localparam int unsigned ATTR_BRIGHT_BIT = 6;
    localparam int unsigned ATTR_FLASH_BIT  = 7;

    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_MISSING = 4'd1,
        CMD_UP      = 4'd2,
        CMD_DOWN    = 4'd3,
        CMD_RIGHT   = 4'd4,
        CMD_LEFT    = 4'd5,
        CMD_PLACE   = 4'd6,
        CMD_ERASE   = 4'd7,
        CMD_SGR     = 4'd8
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [NUM_W-1:0]  first;
        logic [NUM_W-1:0]  second;
    } cmd_t;

    typedef struct packed {
        logic [7:0] columns;
        logic [6:0] rows;
        logic [7:0] default_attr;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/aesp_front.sv
`default_nettype none

module aesp_front
    import aesp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] seq_byte,
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_t            q_cmd
);

    typedef enum logic [2:0] {
        PHASE_FIRST  = 3'b001,
        PHASE_SECOND = 3'b010,
        PHASE_DONE   = 3'b100
    } phase_t;

    logic               seen_reg,   seen_next;
    phase_t             phase_reg,  phase_next;
    logic [NUM_W-1:0]   first_reg,  first_next;
    logic [NUM_W-1:0]   second_reg, second_next;
    logic [CHARS_W-1:0] chars_reg,  chars_next;

    logic       is_digit;
    logic [7:0] digit_byte;

    // Append one decimal digit, saturating
    function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [NUM_W+3:0] r;
        r = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NUM_W{1'b0}}, d};
        return (r > {4'd0, NUM_MAX}) ? NUM_MAX : r[NUM_W-1:0];
    endfunction

    assign in_ready   = !q_full;
    assign q_push     = in_valid && in_ready;
    assign is_digit   = seq_byte inside {[CHAR_ZERO:CHAR_NINE]};
    assign digit_byte = seq_byte - CHAR_ZERO;

    // Classify the byte and advance the parameter parser
    always_comb
    begin
        seen_next    = seen_reg;
        phase_next   = phase_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        chars_next   = chars_reg;
        q_cmd.kind   = CMD_NONE;
        q_cmd.first  = first_reg;
        q_cmd.second = second_reg;

        if (!seen_reg)
        begin
            phase_next  = PHASE_FIRST;
            first_next  = '0;
            second_next = '0;
            chars_next  = '0;
            if (seq_byte != CHAR_BRACKET)
            begin
                q_cmd.kind = CMD_MISSING;
            end
            else
            begin
                seen_next = 1'b1;
            end
        end
        else
        begin
            case (seq_byte)
                CHAR_UP:    q_cmd.kind = CMD_UP;
                CHAR_DOWN:  q_cmd.kind = CMD_DOWN;
                CHAR_RIGHT: q_cmd.kind = CMD_RIGHT;
                CHAR_LEFT:  q_cmd.kind = CMD_LEFT;
                CHAR_PLACE: q_cmd.kind = CMD_PLACE;
                CHAR_ERASE: q_cmd.kind = CMD_ERASE;
                CHAR_SGR:   q_cmd.kind = CMD_SGR;
                CHAR_SPACE: q_cmd.kind = CMD_NONE;
                default:
                begin
                    // Store a parameter character while room is left
                    if (chars_reg < CHARS_LIMIT)
                    begin
                        chars_next = chars_reg + 1'b1;
                        case (phase_reg)
                            PHASE_FIRST:
                            begin
                                if (is_digit)
                                    first_next = add_digit(first_reg, digit_byte[3:0]);
                                else if (seq_byte == CHAR_SEMI)
                                    phase_next = PHASE_SECOND;
                                else
                                    phase_next = PHASE_DONE;
                            end
                            PHASE_SECOND:
                            begin
                                if (is_digit)
                                    second_next = add_digit(second_reg, digit_byte[3:0]);
                                else
                                    phase_next = PHASE_DONE;
                            end
                            default: phase_next = PHASE_DONE;
                        endcase
                    end
                end
            endcase

            // Drop the parse state once a final letter ends the sequence
            if (q_cmd.kind != CMD_NONE)
            begin
                seen_next   = 1'b0;
                phase_next  = PHASE_FIRST;
                first_next  = '0;
                second_next = '0;
                chars_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= 1'b0;
            phase_reg  <= PHASE_FIRST;
            first_reg  <= '0;
            second_reg <= '0;
            chars_reg  <= '0;
        end
        else if (q_push)
        begin
            seen_reg   <= seen_next;
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            chars_reg  <= chars_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/aesp_queue.sv
`default_nettype none

module aesp_queue
    import aesp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head_cmd,
    output logic      full,
    output logic      empty
);

    cmd_t                   entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entries[rd_ptr_reg];

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue push without pop lost an entry");

endmodule

`default_nettype wire

>>> rtl/aesp_back.sv
`default_nettype none

module aesp_back
    import aesp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire cmd_t               head_cmd,
    input  wire logic               q_empty,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    sequence_done,
    output logic                    bracket_missing,
    output logic [ROW_W-1:0]        cursor_row,
    output logic [COL_W-1:0]        cursor_col,
    output logic [7:0]              current_attr,
    output logic                    erase_valid,
    output logic [CELL_W-1:0]       erase_start,
    output logic [CELL_W-1:0]       erase_end
);

    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [7:0]        attr_reg, attr_next;

    logic              out_valid_reg;
    logic              done_reg,    done_next;
    logic              missing_reg, missing_next;
    logic              ev_reg,      ev_next;
    logic [CELL_W-1:0] es_reg,      es_next;
    logic [CELL_W-1:0] ee_reg,      ee_next;

    logic [7:0]        cols_eff;
    logic [6:0]        rows_eff;
    logic [7:0]        cols_less;
    logic [6:0]        rows_less;
    logic [COL_W-1:0]  col_max;
    logic [ROW_W-1:0]  row_max;
    logic [NUM_W-1:0]  n;
    logic [NUM_W-1:0]  step;
    logic [NUM_W-1:0]  n_less;
    logic [NUM_W-1:0]  m_less;
    logic [NUM_W:0]    row_sum;
    logic [NUM_W:0]    col_sum;
    logic [CELL_W-1:0] row_cells;
    logic [CELL_W:0]   cur_raw;
    logic [CELL_W-1:0] total;
    logic [CELL_W-1:0] cur;
    logic [NUM_W-1:0]  pen_off;
    logic [NUM_W-1:0]  back_off;

    assign q_pop = !q_empty && (!out_valid_reg || out_ready);

    // Effective screen size
    always_comb
    begin
        if (cfg.columns == '0)
            cols_eff = 8'd1;
        else if (cfg.columns > MAX_COLUMNS)
            cols_eff = MAX_COLUMNS;
        else
            cols_eff = cfg.columns;

        if (cfg.rows == '0)
            rows_eff = 7'd1;
        else if (cfg.rows > MAX_ROWS)
            rows_eff = MAX_ROWS;
        else
            rows_eff = cfg.rows;
    end

    assign cols_less = cols_eff - 8'd1;
    assign rows_less = rows_eff - 7'd1;
    assign col_max   = cols_less[COL_W-1:0];
    assign row_max   = rows_less[ROW_W-1:0];

    // Operands shared by the commands
    assign n         = head_cmd.first;
    assign step      = (n == '0) ? NUM_W'(1) : n;
    assign n_less    = (n == '0) ? '0 : n - 1'b1;
    assign m_less    = (head_cmd.second == '0) ? '0 : head_cmd.second - 1'b1;
    assign row_sum   = {{(NUM_W+1-ROW_W){1'b0}}, row_reg} + {1'b0, step};
    assign col_sum   = {{(NUM_W+1-COL_W){1'b0}}, col_reg} + {1'b0, step};
    assign row_cells = CELL_W'(row_reg) * CELL_W'(cols_eff);
    assign cur_raw   = {1'b0, row_cells} + (CELL_W+1)'(col_reg);
    assign total     = CELL_W'(cols_eff) * CELL_W'(rows_eff);
    assign cur       = (cur_raw > {1'b0, total}) ? total : cur_raw[CELL_W-1:0];
    assign pen_off   = n - SGR_PEN_FIRST;
    assign back_off  = n - SGR_BACK_FIRST;

    // Execute the command at the queue head
    always_comb
    begin
        row_next     = row_reg;
        col_next     = col_reg;
        attr_next    = attr_reg;
        done_next    = 1'b1;
        missing_next = 1'b0;
        ev_next      = 1'b0;
        es_next      = '0;
        ee_next      = '0;

        case (head_cmd.kind)
            CMD_NONE:
            begin
                done_next = 1'b0;
            end
            CMD_MISSING:
            begin
                missing_next = 1'b1;
            end
            CMD_UP:
            begin
                if (NUM_W'(row_reg) > step)
                    row_next = row_reg - step[ROW_W-1:0];
                else
                    row_next = '0;
            end
            CMD_DOWN:
            begin
                if (row_sum > (NUM_W+1)'(row_max))
                    row_next = row_max;
                else
                    row_next = row_sum[ROW_W-1:0];
            end
            CMD_RIGHT:
            begin
                if (col_sum > (NUM_W+1)'(col_max))
                    col_next = col_max;
                else
                    col_next = col_sum[COL_W-1:0];
            end
            CMD_LEFT:
            begin
                if (NUM_W'(col_reg) > step)
                    col_next = col_reg - step[COL_W-1:0];
                else
                    col_next = '0;
            end
            CMD_PLACE:
            begin
                row_next = (n_less > NUM_W'(row_max)) ? row_max : n_less[ROW_W-1:0];
                col_next = (m_less > NUM_W'(col_max)) ? col_max : m_less[COL_W-1:0];
            end
            CMD_ERASE:
            begin
                if (n == ERASE_TO_END)
                begin
                    ev_next = 1'b1;
                    es_next = cur;
                    ee_next = total;
                end
                else if (n == ERASE_TO_CURSOR)
                begin
                    ev_next = 1'b1;
                    ee_next = cur;
                end
                else if (n == ERASE_ALL || n == ERASE_ALL_SCROLL)
                begin
                    ev_next = 1'b1;
                    ee_next = total;
                end
            end
            CMD_SGR:
            begin
                if (n == SGR_RESET)
                    attr_next = cfg.default_attr;
                else if (n == SGR_BRIGHT)
                    attr_next[ATTR_BRIGHT_BIT] = 1'b1;
                else if (n == SGR_FLASH_SLOW || n == SGR_FLASH_FAST)
                    attr_next[ATTR_FLASH_BIT] = 1'b1;
                else if (n == SGR_NORMAL)
                    attr_next[ATTR_BRIGHT_BIT] = 1'b0;
                else if (n == SGR_STEADY)
                    attr_next[ATTR_FLASH_BIT] = 1'b0;
                else if (n inside {[SGR_PEN_FIRST:SGR_PEN_LAST]})
                    attr_next[2:0] = pen_off[2:0];
                else if (n inside {[SGR_BACK_FIRST:SGR_BACK_LAST]})
                    attr_next[5:3] = back_off[2:0];
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Update cursor, attribute and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                row_reg       <= row_next;
                col_reg       <= col_next;
                attr_reg      <= attr_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            done_reg    <= done_next;
            missing_reg <= missing_next;
            ev_reg      <= ev_next;
            es_reg      <= es_next;
            ee_reg      <= ee_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sequence_done   = done_reg;
    assign bracket_missing = missing_reg;
    assign cursor_row      = row_reg;
    assign cursor_col      = col_reg;
    assign current_attr    = attr_reg;
    assign erase_valid     = ev_reg;
    assign erase_start     = es_reg;
    assign erase_end       = ee_reg;

    a_missing_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && missing_reg) |-> done_reg)
        else $error("missing bracket reported without sequence end");

    a_no_erase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ev_reg) |-> (es_reg == '0 && ee_reg == '0))
        else $error("erase range set without erase");

    a_erase_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ev_reg) |-> (es_reg <= ee_reg))
        else $error("erase range reversed");

endmodule

`default_nettype wire

>>> rtl/ansi_escape_sequence_parser.sv
// Parser for the bytes that follow ESC in an ANSI terminal stream. Each byte
// taken on the input channel gives exactly one result transaction, which shows
// whether the sequence ended, the cursor and attribute after the byte, and an
// erase range of cell indexes for J. The block takes one byte per clock cycle
// sustained while out_ready holds; the command for a byte enters the queue at
// the accepting edge and the executer registers its result when it pops the
// command. The rate is set by the executer, whose cursor update for one byte
// feeds the next. A two-entry command queue parts
// the two halves, so two more bytes are taken while a result waits before the
// input stalls. cursor_row, cursor_col and current_attr always show the state
// after the byte whose result is on the output. Write the configuration
// registers only while no transaction is in flight.
`default_nettype none

module ansi_escape_sequence_parser
    import aesp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         seq_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    sequence_done,
    output logic                    bracket_missing,
    output logic [ROW_W-1:0]        cursor_row,
    output logic [COL_W-1:0]        cursor_col,
    output logic [7:0]              current_attr,
    output logic                    erase_valid,
    output logic [CELL_W-1:0]       erase_start,
    output logic [CELL_W-1:0]       erase_end,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_wdata
);

    logic [7:0] screen_columns_reg;
    logic [6:0] screen_rows_reg;
    logic [7:0] default_attribute_reg;
    cfg_t       cfg;

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    cmd_t       push_cmd;
    cmd_t       head_cmd;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_columns_reg    <= COLUMNS_RESET;
            screen_rows_reg       <= ROWS_RESET;
            default_attribute_reg <= ATTR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_COLUMNS:    screen_columns_reg    <= cfg_wdata;
                REG_SCREEN_ROWS:       screen_rows_reg       <= cfg_wdata[6:0];
                REG_DEFAULT_ATTRIBUTE: default_attribute_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.columns      = screen_columns_reg;
    assign cfg.rows         = screen_rows_reg;
    assign cfg.default_attr = default_attribute_reg;

    aesp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .seq_byte (seq_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    aesp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    aesp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .head_cmd        (head_cmd),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sequence_done   (sequence_done),
        .bracket_missing (bracket_missing),
        .cursor_row      (cursor_row),
        .cursor_col      (cursor_col),
        .current_attr    (current_attr),
        .erase_valid     (erase_valid),
        .erase_start     (erase_start),
        .erase_end       (erase_end)
    );

endmodule

`default_nettype wire
